// ===== hdl/sepq_pkg.sv =====
// sepq_pkg: shared types and constants of the stable event priority queue
// used by sepq_cell and stable_event_priority_queue_unit, no dependencies

package sepq_pkg;

  // number of slots in the cell chain
  localparam int unsigned Depth = 16;
  // width of the held entry counter, holds 0 .. Depth
  localparam int unsigned CntW = $clog2(Depth + 1);

  // field widths of the request and result items
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 2;

  // request kinds
  localparam logic KindInsert = 1'b0;
  localparam logic KindRemove = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd1;
  localparam logic [StatusW-1:0] StatusFull  = 2'd2;

  // one queue entry
  typedef struct packed {
    logic [TimeW-1:0]   ev_time;
    logic [PrioW-1:0]   prio;
    logic [HandleW-1:0] handle;
  } entry_t;

  // what a cell shows to its neighbors
  typedef struct packed {
    logic   occ;
    logic   stays;
    entry_t entry;
  } cell_view_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ===== hdl/sepq_cell.sv =====
// sepq_cell: one slot of the sorted shift chain
// depends on sepq_pkg for the entry, view and control types

module sepq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sepq_pkg::cell_ctrl_t ctrl_i,
  input  sepq_pkg::cell_view_t left_i,
  input  sepq_pkg::cell_view_t right_i,
  output sepq_pkg::cell_view_t view_o,
  output sepq_pkg::entry_t     entry_d_o,
  output logic                occ_d_o
);

  sepq_pkg::entry_t entry_q, entry_d;
  logic             occ_q, occ_d;
  logic             stays;

  // held entry keeps its place when its key is equal or smaller
  always_comb begin
    stays = occ_q &&
            ((entry_q.ev_time < ctrl_i.new_entry.ev_time) ||
             ((entry_q.ev_time == ctrl_i.new_entry.ev_time) &&
              (entry_q.prio <= ctrl_i.new_entry.prio)));
  end

  // insert shifts toward the tail, pop shifts toward the head
  always_comb begin
    entry_d = entry_q;
    occ_d   = occ_q;
    if (ctrl_i.ins) begin
      occ_d = occ_q | left_i.occ;
      if (!stays) begin
        entry_d = left_i.stays ? ctrl_i.new_entry : left_i.entry;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i.entry;
      occ_d   = right_i.occ;
    end
  end

  // occupancy is control state, entry payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign view_o.occ   = occ_q;
  assign view_o.stays = stays;
  assign view_o.entry = entry_q;
  assign entry_d_o    = entry_d;
  assign occ_d_o      = occ_d;

endmodule

// ===== hdl/stable_event_priority_queue_unit.sv =====
// stable_event_priority_queue_unit: top level of the bounded event queue
// depends on sepq_pkg and sepq_cell
//
// usage:
//   s_axis carries requests: tuser is the kind (insert or remove head),
//   tdata the time, tie priority and handle of an inserted entry.
//   m_axis carries one result per request: tuser is the status
//   (ok, remove on empty, insert on full dropped), tdata the popped entry,
//   the head entry after the step and the entry count.
//   the queue is a row of Depth cells kept sorted by (time, priority);
//   every cell compares its entry with the new one in parallel and either
//   keeps it, takes the new entry or takes its neighbor's, so equal keys
//   leave first-in first-out.
//   the result is registered and appears in the cycle after its request is accepted.
//   throughput: one request per cycle while the receiver does not stall, set by
//   the cell row and the output register updating together on each request.
//   when the receiver stalls the result is held in the output register and
//   s_axis_tready drops until it is taken; a request is taken in the
//   same cycle the waiting result leaves.
//   reset empties the queue and clears the output valid; entry payload
//   registers are not cleared and are never read while unoccupied.

module stable_event_priority_queue_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // fields from bit 0: entry_time[31:0], entry_prio[39:32], entry_handle[55:40]
  input  logic [55:0]   s_axis_tdata,
  // fields from bit 0: kind[0]
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // fields from bit 0: removed_time[31:0], removed_handle[47:32],
  // head_valid[48], head_time[80:49], head_handle[96:81], entry_count[101:97]
  output logic [103:0]  m_axis_tdata,
  // fields from bit 0: status[1:0]
  output logic [1:0]    m_axis_tuser
);

  localparam int unsigned Depth = sepq_pkg::Depth;

  sepq_pkg::cell_ctrl_t ctrl;
  sepq_pkg::cell_view_t view      [Depth];
  sepq_pkg::cell_view_t left_view [Depth];
  sepq_pkg::cell_view_t right_view[Depth];
  sepq_pkg::entry_t     entry_d   [Depth];
  logic                 occ_d     [Depth];
  logic [Depth-1:0]     occ_vec;

  logic                           accept;
  logic                           is_remove;
  logic                           empty;
  logic                           full;
  logic [sepq_pkg::CntW-1:0]      count_q, count_d;

  logic                           out_valid_q;
  logic [sepq_pkg::StatusW-1:0]   status_q, status_d;
  logic [sepq_pkg::TimeW-1:0]     rem_time_q, rem_time_d;
  logic [sepq_pkg::HandleW-1:0]   rem_handle_q, rem_handle_d;
  logic                           head_valid_q;
  logic [sepq_pkg::TimeW-1:0]     head_time_q, head_time_d;
  logic [sepq_pkg::HandleW-1:0]   head_handle_q, head_handle_d;

  // request handshake and queue condition
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_remove     = (s_axis_tuser[0] == sepq_pkg::KindRemove);
  assign empty         = !view[0].occ;
  assign full          = view[Depth-1].occ;

  // operation broadcast to the cells
  always_comb begin
    ctrl.ins               = accept && !is_remove && !full;
    ctrl.pop               = accept && is_remove && !empty;
    ctrl.new_entry.ev_time = s_axis_tdata[31:0];
    ctrl.new_entry.prio    = s_axis_tdata[39:32];
    ctrl.new_entry.handle  = s_axis_tdata[55:40];
  end

  // neighbor wiring, the head sees a staying occupied cell on its left
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (i == 0) begin
        left_view[i].occ   = 1'b1;
        left_view[i].stays = 1'b1;
        left_view[i].entry = '0;
      end else begin
        left_view[i] = view[i-1];
      end
      if (i == Depth - 1) begin
        right_view[i] = '0;
      end else begin
        right_view[i] = view[i+1];
      end
      occ_vec[i] = view[i].occ;
    end
  end

  // the cell row
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    sepq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_view[g]),
      .right_i   (right_view[g]),
      .view_o    (view[g]),
      .entry_d_o (entry_d[g]),
      .occ_d_o   (occ_d[g])
    );
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  // result of the step
  always_comb begin
    status_d     = sepq_pkg::StatusOk;
    rem_time_d   = '0;
    rem_handle_d = '0;
    if (is_remove && empty) begin
      status_d = sepq_pkg::StatusEmpty;
    end else if (!is_remove && full) begin
      status_d = sepq_pkg::StatusFull;
    end
    if (ctrl.pop) begin
      rem_time_d   = view[0].entry.ev_time;
      rem_handle_d = view[0].entry.handle;
    end
    head_time_d   = occ_d[0] ? entry_d[0].ev_time : '0;
    head_handle_d = occ_d[0] ? entry_d[0].handle  : '0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      rem_time_q    <= rem_time_d;
      rem_handle_q  <= rem_handle_d;
      head_valid_q  <= occ_d[0];
      head_time_q   <= head_time_d;
      head_handle_q <= head_handle_d;
    end
  end

  // result packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b00,
                          sepq_pkg::CountW'(count_q),
                          head_handle_q,
                          head_time_q,
                          head_valid_q,
                          rem_handle_q,
                          rem_time_q};

  // occupied cells always form a prefix whose length is the count
  a_occ_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_vec == Depth'((Depth+1)'(1) << count_q) - Depth'(1))
    else $error("occupied cells do not match entry count");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sepq_pkg::CntW'(Depth))
    else $error("entry count above depth");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("no result after accepted request");

  a_head_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (m_axis_tdata[48] == (count_q != '0)))
    else $error("head valid disagrees with entry count");

endmodule
